[rtl/prs_pkg.sv]
`timescale 1ns / 1ps

package prs_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_SENT    = 2'd2,
    OP_RX_DATA = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_SEND     = 3'd1,
    ACT_READ     = 3'd2,
    ACT_WR_DONE  = 3'd3,
    ACT_RD_DONE  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WR_BLOCK  = 3'd1,
    PH_WR_DATA   = 3'd2,
    PH_RD_BLOCK  = 3'd3,
    PH_RD_OFFSET = 3'd4,
    PH_RD_DATA   = 3'd5
  } phase_t;

  localparam logic [7:0] NO_BLOCK = 8'hff;

  typedef struct packed {
    op_t         operation;
    logic [7:0]  reg_block;
    logic [6:0]  reg_offset;
    logic        two_byte;
    logic [15:0] write_data;
    logic [7:0]  requester;
    logic        send_ok;
    logic [15:0] rx_data;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  byte_count;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic [7:0]  tx_byte2;
    logic        status;
    logic [15:0] result_data;
    logic [7:0]  done_block;
    logic [6:0]  done_offset;
    logic [7:0]  reply_to;
  } result_t;

  typedef struct packed {
    logic [7:0]  selected_block;
    logic [7:0]  pending_block;
    logic [6:0]  pending_offset;
    logic        pending_wide;
    logic [15:0] pending_value;
    logic [7:0]  pending_client;
  } ctx_t;

endpackage

[rtl/prs_step.sv]
`timescale 1ns / 1ps

module prs_step import prs_pkg::*; (
  input  item_t      item,
  input  phase_t     phase,
  input  ctx_t       ctx,
  input  logic [6:0] block_select_offset,
  output phase_t     phase_nxt,
  output ctx_t       ctx_nxt,
  output result_t    result
);

  logic [7:0] sel_byte;
  logic [7:0] wr_byte;
  logic [7:0] rd_byte;

  assign sel_byte = {block_select_offset, 1'b0};
  assign wr_byte  = {ctx.pending_offset, 1'b0};
  assign rd_byte  = {ctx.pending_offset, 1'b1};

  always_comb begin
    phase_nxt = phase;
    ctx_nxt   = ctx;
    result    = '0;
    result.action = ACT_NONE;
    unique case (item.operation)
      OP_WRITE: begin
        ctx_nxt.pending_block  = item.reg_block;
        ctx_nxt.pending_offset = item.reg_offset;
        ctx_nxt.pending_wide   = item.two_byte;
        ctx_nxt.pending_value  = item.write_data;
        ctx_nxt.pending_client = item.requester;
        result.action = ACT_SEND;
        if (item.reg_block != ctx.selected_block) begin
          phase_nxt         = PH_WR_BLOCK;
          result.byte_count = 2'd2;
          result.tx_byte0   = sel_byte;
          result.tx_byte1   = item.reg_block;
        end else begin
          phase_nxt         = PH_WR_DATA;
          result.byte_count = item.two_byte ? 2'd3 : 2'd2;
          result.tx_byte0   = {item.reg_offset, 1'b0};
          result.tx_byte1   = item.write_data[7:0];
          result.tx_byte2   = item.two_byte ? item.write_data[15:8] : 8'd0;
        end
      end
      OP_READ: begin
        if (phase != PH_IDLE) begin
          // abandoned access: error goes to the pending client
          phase_nxt          = PH_IDLE;
          result.action      = ACT_RD_DONE;
          result.status      = 1'b1;
          result.done_block  = item.reg_block;
          result.done_offset = item.reg_offset;
          result.reply_to    = ctx.pending_client;
        end else begin
          ctx_nxt.pending_block  = item.reg_block;
          ctx_nxt.pending_offset = item.reg_offset;
          ctx_nxt.pending_wide   = item.two_byte;
          ctx_nxt.pending_client = item.requester;
          result.action = ACT_SEND;
          if (item.reg_block != ctx.selected_block) begin
            phase_nxt         = PH_RD_BLOCK;
            result.byte_count = 2'd2;
            result.tx_byte0   = sel_byte;
            result.tx_byte1   = item.reg_block;
          end else begin
            phase_nxt         = PH_RD_OFFSET;
            result.byte_count = 2'd1;
            result.tx_byte0   = {item.reg_offset, 1'b1};
          end
        end
      end
      OP_SENT: begin
        if (!item.send_ok) begin
          if (phase == PH_WR_BLOCK || phase == PH_WR_DATA) begin
            phase_nxt          = PH_IDLE;
            result.action      = ACT_WR_DONE;
            result.status      = 1'b1;
            result.result_data = ctx.pending_value;
            result.done_block  = ctx.pending_block;
            result.done_offset = ctx.pending_offset;
            result.reply_to    = ctx.pending_client;
          end else if (phase == PH_RD_BLOCK || phase == PH_RD_OFFSET) begin
            phase_nxt          = PH_IDLE;
            result.action      = ACT_RD_DONE;
            result.status      = 1'b1;
            result.done_block  = ctx.pending_block;
            result.done_offset = ctx.pending_offset;
            result.reply_to    = ctx.pending_client;
          end
        end else begin
          unique case (phase)
            PH_WR_BLOCK: begin
              ctx_nxt.selected_block = ctx.pending_block;
              phase_nxt         = PH_WR_DATA;
              result.action     = ACT_SEND;
              result.byte_count = ctx.pending_wide ? 2'd3 : 2'd2;
              result.tx_byte0   = wr_byte;
              result.tx_byte1   = ctx.pending_value[7:0];
              result.tx_byte2   = ctx.pending_wide ? ctx.pending_value[15:8] : 8'd0;
            end
            PH_WR_DATA: begin
              phase_nxt          = PH_IDLE;
              result.action      = ACT_WR_DONE;
              result.result_data = ctx.pending_value;
              result.done_block  = ctx.pending_block;
              result.done_offset = ctx.pending_offset;
              result.reply_to    = ctx.pending_client;
            end
            PH_RD_BLOCK: begin
              ctx_nxt.selected_block = ctx.pending_block;
              phase_nxt         = PH_RD_OFFSET;
              result.action     = ACT_SEND;
              result.byte_count = 2'd1;
              result.tx_byte0   = rd_byte;
            end
            PH_RD_OFFSET: begin
              phase_nxt         = PH_RD_DATA;
              result.action     = ACT_READ;
              result.byte_count = ctx.pending_wide ? 2'd2 : 2'd1;
            end
            default: begin
            end
          endcase
        end
      end
      OP_RX_DATA: begin
        if (phase == PH_RD_DATA) begin
          phase_nxt = PH_IDLE;
          ctx_nxt.pending_value = ctx.pending_wide ? item.rx_data
                                                   : {8'd0, item.rx_data[7:0]};
          result.action      = ACT_RD_DONE;
          result.result_data = ctx_nxt.pending_value;
          result.done_block  = ctx.pending_block;
          result.done_offset = ctx.pending_offset;
          result.reply_to    = ctx.pending_client;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/paged_register_access_sequencer.sv]
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------------------
// in_      | input     | in_valid / in_stall    | operation, block, offset, data, client
// out_     | output    | out_valid / out_stall  | bus action, tx bytes, completion fields
// cfg_     | input     | cfg_wr_en              | block select register offset
//
// one request accepted per cycle while in_stall is low; every request yields exactly one result
// a request passes the input register, then the phase step into the result register
// the step reads and updates the phase and pending context in the same cycle
// rst_n is synchronous: phase idle, no block selected, both stages empty
// a stalled result holds its stage; the input stage fills behind it, then stalls

module paged_register_access_sequencer import prs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_reg_block,
  input  logic [6:0]  in_reg_offset,
  input  logic        in_two_byte,
  input  logic [15:0] in_write_data,
  input  logic [7:0]  in_requester,
  input  logic        in_send_ok,
  input  logic [15:0] in_rx_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [1:0]  out_byte_count,
  output logic [7:0]  out_tx_byte0,
  output logic [7:0]  out_tx_byte1,
  output logic [7:0]  out_tx_byte2,
  output logic        out_status,
  output logic [15:0] out_result_data,
  output logic [7:0]  out_done_block,
  output logic [6:0]  out_done_offset,
  output logic [7:0]  out_reply_to
);

  // block select register offset
  logic [6:0] bsel_off_r;

  // input stage
  logic       s1_valid_r;
  item_t      s1_item_r;

  // sequencer state
  phase_t     phase_r;
  phase_t     phase_nxt;
  ctx_t       ctx_r;
  ctx_t       ctx_nxt;

  // result stage
  logic       out_valid_r;
  result_t    out_r;
  result_t    step_result;

  logic       advance;

  // the input stage moves on when the result stage is empty or being drained
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsel_off_r <= '0;
    end else if (cfg_wr_en) begin
      bsel_off_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r.operation  <= op_t'(in_operation);
      s1_item_r.reg_block  <= in_reg_block;
      s1_item_r.reg_offset <= in_reg_offset;
      s1_item_r.two_byte   <= in_two_byte;
      s1_item_r.write_data <= in_write_data;
      s1_item_r.requester  <= in_requester;
      s1_item_r.send_ok    <= in_send_ok;
      s1_item_r.rx_data    <= in_rx_data;
    end
  end

  // phase step: next phase, pending context and the result for this request
  prs_step u_step (
    .item                (s1_item_r),
    .phase               (phase_r),
    .ctx                 (ctx_r),
    .block_select_offset (bsel_off_r),
    .phase_nxt           (phase_nxt),
    .ctx_nxt             (ctx_nxt),
    .result              (step_result)
  );

  // phase and context only change when a request passes into the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ctx_r   <= '{selected_block: NO_BLOCK, default: '0};
    end else if (advance) begin
      phase_r <= phase_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= step_result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_byte_count  = out_r.byte_count;
  assign out_tx_byte0    = out_r.tx_byte0;
  assign out_tx_byte1    = out_r.tx_byte1;
  assign out_tx_byte2    = out_r.tx_byte2;
  assign out_status      = out_r.status;
  assign out_result_data = out_r.result_data;
  assign out_done_block  = out_r.done_block;
  assign out_done_offset = out_r.done_offset;
  assign out_reply_to    = out_r.reply_to;

endmodule
